// ===== src/sbh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbh_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  typedef logic [31:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;  // write in_data at fill position
    logic pad_byte;    // write padding byte at fill position
    logic mark_byte;   // the padding byte is the 0x80 end marker
    logic len_byte;    // padding in the length field carries the bit length
    logic count_byte;  // add one to the byte total
    logic start_comp;  // load working registers, begin rounds
    logic round_step;  // perform one round
    logic finish_comp; // add working registers into hash
    logic clear_fill;  // fill position back to zero
    logic reset_msg;   // reinitialise for a new message
    logic shift_out;   // rotate hash words towards the output
  } sbh_cmd_t;

  typedef struct packed {
    logic [6:0] fill;      // bytes held
    logic       round_end; // current round is the last one
  } sbh_stat_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

endpackage
`default_nettype wire

// ===== src/sbh_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       has_data;
  logic       last;
  modport source (output valid, data, has_data, last, input ready);
  modport sink (input valid, data, has_data, last, output ready);
endinterface

interface sbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== src/sbh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbh_datapath
  import sbh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sbh_cmd_t  cmd,
  input  wire logic [7:0] byte_in,
  output sbh_stat_t      stat,
  output word_t          hash_top
);

  localparam logic [6:0] LenPos = 7'(BlockBytes - 8);

  // Message schedule kept as a 16-word window; bytes land in it directly.
  word_t      w_r [16];
  word_t      h_r [8];
  word_t      a_r [8];
  logic [6:0] fill_r;
  logic [5:0] rnd_r;
  logic [63:0] total_r;

  function automatic word_t ror(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  logic [7:0] pad_val;
  logic [3:0] wi;
  logic [1:0] bi;
  word_t      t1, t2, wnew, wcur;
  logic [63:0] bits;

  always_comb begin
    bits = {total_r[60:0], 3'b000};
    wi   = fill_r[5:2];
    bi   = fill_r[1:0];
    // Padding is a zero unless it is the end marker or a byte of the length.
    pad_val = 8'h00;
    if (cmd.mark_byte)
      pad_val = 8'h80;
    else if (cmd.len_byte && fill_r >= LenPos)
      pad_val = bits[8'(63 - 8 * (fill_r - LenPos)) -: 8];
    wcur = w_r[0];
    t1 = a_r[7] + (ror(a_r[4], 6) ^ ror(a_r[4], 11) ^ ror(a_r[4], 25))
       + ((a_r[4] & a_r[5]) ^ (~a_r[4] & a_r[6])) + round_k(rnd_r) + wcur;
    t2 = (ror(a_r[0], 2) ^ ror(a_r[0], 13) ^ ror(a_r[0], 22))
       + ((a_r[0] & a_r[1]) ^ (a_r[0] & a_r[2]) ^ (a_r[1] & a_r[2]));
    wnew = (ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
         + (ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
  end

  assign stat     = {fill_r, rnd_r == 6'(Rounds - 1)};
  assign hash_top = h_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
      rnd_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      if (cmd.store_byte || cmd.pad_byte) begin
        w_r[wi][8'(31 - 8 * bi) -: 8] <= cmd.store_byte ? byte_in : pad_val;
        fill_r <= fill_r + 7'd1;
      end
      if (cmd.count_byte) total_r <= total_r + 64'd1;
      if (cmd.clear_fill) fill_r <= '0;
      if (cmd.start_comp) begin
        for (int i = 0; i < 8; i++) a_r[i] <= h_r[i];
        rnd_r <= '0;
      end
      if (cmd.round_step) begin
        a_r[0] <= t1 + t2;
        a_r[1] <= a_r[0];
        a_r[2] <= a_r[1];
        a_r[3] <= a_r[2];
        a_r[4] <= a_r[3] + t1;
        a_r[5] <= a_r[4];
        a_r[6] <= a_r[5];
        a_r[7] <= a_r[6];
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.finish_comp)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + a_r[i];
      if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
      if (cmd.reset_msg) begin
        for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
        total_r <= '0;
        fill_r  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sbh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbh_ctrl
  import sbh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_has_data,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     word_idx,
  input  wire sbh_stat_t stat,
  output sbh_cmd_t       cmd
);

  localparam logic [6:0] LastPos = 7'(BlockBytes - 1);
  localparam logic [6:0] LenPos  = 7'(BlockBytes - 8);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COMP  = 7'b0000010,
    S_FIN   = 7'b0000100,
    S_PAD80 = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_START = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;       // message end pending
  logic       marker_r, marker_nxt; // end marker already written
  logic       padded_r, padded_nxt; // current block carries the length
  logic [2:0] idx_r, idx_nxt;

  assign word_idx  = idx_r;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    fin_nxt = fin_r;
    marker_nxt = marker_r;
    padded_nxt = padded_r;
    idx_nxt = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          fin_nxt = in_last;
          marker_nxt = 1'b0;
          padded_nxt = 1'b0;
          if (in_has_data) begin
            cmd.store_byte = 1'b1;
            cmd.count_byte = 1'b1;
            if (stat.fill == LastPos) state_nxt = S_START;
            else if (in_last) state_nxt = S_PAD80;
          end else if (in_last) state_nxt = S_PAD80;
        end
      end
      S_START: begin
        cmd.start_comp = 1'b1;
        cmd.clear_fill = 1'b1;
        state_nxt = S_COMP;
      end
      S_COMP: begin
        cmd.round_step = 1'b1;
        if (stat.round_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_comp = 1'b1;
        if (!fin_r) state_nxt = S_IDLE;
        else if (padded_r) begin
          state_nxt = S_OUT;
          idx_nxt = '0;
        end else if (marker_r) begin
          // The marker left no room for the length: a block of zeros and the length follows.
          state_nxt = S_PAD;
          padded_nxt = 1'b1;
        end else state_nxt = S_PAD80;
      end
      S_PAD80: begin
        // The length fits in this block only if the marker lands before it.
        cmd.pad_byte = 1'b1;
        cmd.mark_byte = 1'b1;
        marker_nxt = 1'b1;
        padded_nxt = (stat.fill < LenPos);
        if (stat.fill == LastPos) state_nxt = S_START;
        else state_nxt = S_PAD;
      end
      S_PAD: begin
        cmd.pad_byte = 1'b1;
        cmd.len_byte = padded_r;
        if (stat.fill == LastPos) state_nxt = S_START;
      end
      S_OUT: begin
        if (out_ready) begin
          if (idx_r == 3'd7) begin
            cmd.reset_msg = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.shift_out = 1'b1;
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      marker_r <= 1'b0;
      padded_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      marker_r <= marker_nxt;
      padded_r <= padded_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 hasher taking the message one byte word at a time.
// Input channel: data, has_data, last. A word with has_data low and last
// high closes the message without adding a byte; one with both low is
// accepted and does nothing.
// Output channel: eight digest words, most significant first, with
// word_index 0..7 and last_word set on the eighth.
// Throughput: a byte word takes one cycle while the block is idle; the
// 64th byte of a block holds the input while the single round unit runs
// 64 rounds and the hash is updated. The closing word costs the padding
// fill, one byte a cycle, plus one or two compressions, before the first
// digest word shows. Reset (synchronous, rst_n low) reloads the initial
// hash and empties the block. A stalled receiver simply holds the current
// digest word; no new input is taken until all eight have gone.
module sha256_byte_stream_hasher
  import sbh_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  sbh_in_if.sink   in_ch,
  sbh_out_if.source out_ch
);

  sbh_cmd_t  cmd;
  sbh_stat_t stat;
  word_t     hash_top;
  logic [2:0] idx;

  sbh_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_has_data(in_ch.has_data), .in_last(in_ch.last),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_idx(idx), .stat, .cmd
  );

  sbh_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_ch.data), .stat, .hash_top
  );

  assign out_ch.digest_word = hash_top;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 3'd7);

endmodule
`default_nettype wire

// ===== tb/sbh_tb_if.sv =====
`timescale 1ns / 1ps
// The channel interfaces are defined alongside the RTL in src/sbh_if.sv.
// This file only holds a small bundle for the checker's result counters.
interface sbh_tally_if;
  int unsigned fails;
  int unsigned digests_seen;
  int unsigned pending;
endinterface

// ===== tb/sbh_digest_checker.sv =====
`timescale 1ns / 1ps
module sbh_digest_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] in_data,
  input  logic in_has_data,
  input  logic in_last,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0] out_word_index,
  input  logic out_last_word,
  output int unsigned fail_count,
  output int unsigned words_checked,
  output int unsigned words_pending
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HINIT [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] msg_bytes;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    r = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + KTAB[i] + w[i];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += r[i];
  endtask

  task automatic restart();
    chain = HINIT;
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic absorb(logic [7:0] b, logic hd, logic lst);
    logic [63:0] bits;
    digest_word_t dw;
    if (hd) begin
      blk[fill] = b;
      fill++;
      msg_bytes++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (lst) begin
      bits = msg_bytes << 3;
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        compress();
        fill = 0;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = chain[i];
        dw.word_index = 3'(i);
        dw.last_word = (i == 7);
        digest_q.push_back(dw);
      end
      restart();
    end
  endtask

  initial begin
    fail_count = 0;
    words_checked = 0;
    restart();
  end

  assign words_pending = digest_q.size();

  always @(posedge clk) begin
    digest_word_t want;
    digest_word_t got;
    if (!rst_n) begin
      restart();
    end else begin
      if (in_valid && in_ready) absorb(in_data, in_has_data, in_last);
      if (out_valid && out_ready) begin
        got = {out_digest_word, out_word_index, out_last_word};
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected digest word %h (index %0d)", got.digest_word,
                     got.word_index);
        end else begin
          want = digest_q.pop_front();
          words_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sha256_byte_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned messages_sent;
  bit sink_hold;

  sbh_in_if  in_ch ();
  sbh_out_if out_ch ();
  sbh_tally_if i_tally ();

  sha256_byte_stream_hasher i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // The checker watches both channels and keeps its own running hash state.
  sbh_digest_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data        (in_ch.data),
    .in_has_data    (in_ch.has_data),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_digest_word(out_ch.digest_word),
    .out_word_index (out_ch.word_index),
    .out_last_word  (out_ch.last_word),
    .fail_count     (i_tally.fails),
    .words_checked  (i_tally.digests_seen),
    .words_pending  (i_tally.pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one; two in five gaps are zero.
  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word and wait until the block takes it. The valid line stays
  // high between back-to-back words, so it is never dropped and raised in
  // the same step.
  task automatic send_word(logic [7:0] b, logic hd, logic lst, bit with_gaps);
    int unsigned idle;
    idle = with_gaps ? gap_len() : 0;
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.data     <= b;
    in_ch.has_data <= hd;
    in_ch.last     <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (lst) messages_sent++;
  endtask

  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (i_tally.pending != 0) @(posedge clk);
  endtask

  // A well-formed message of the given length: random bytes, with gaps also
  // sprinkled with idle words, closed either on its final byte or by an
  // end-only word.
  task automatic send_message(int unsigned len, bit with_gaps);
    bit end_only;
    end_only = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_gaps && $urandom_range(0, 9) == 0)
        send_word(8'($urandom), 1'b0, 1'b0, with_gaps);
      send_word(8'($urandom), 1'b1, !end_only && (i == len - 1), with_gaps);
    end
    if (end_only) send_word(8'($urandom), 1'b0, 1'b1, with_gaps);
  endtask

  // Receiver side: random stalls, one long hold-off requested by the stimulus.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      stall = gap_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog: ends the run as a failure once the cycle counter passes the timeout limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned tail;
    cycle_count = 0;
    words_sent = 0;
    messages_sent = 0;
    sink_hold = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    in_ch.has_data = 1'b0;
    in_ch.last = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty message, idle words, all-ones and all-zeros bytes,
    // a 56-byte message whose length spills into an extra block, and a
    // message that ends exactly on a block boundary.
    send_word(8'h00, 1'b0, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0, 1'b0);
    send_word(8'haa, 1'b1, 1'b0, 1'b0);
    send_word(8'h55, 1'b0, 1'b1, 1'b0);
    drain_digests();
    send_message(56, 1'b1);
    send_message(64, 1'b0);

    // The sender waits here until every digest word has come back.
    drain_digests();

    // Keep offering words while the receiver holds off for a long stretch.
    sink_hold = 1'b1;
    send_message(3, 1'b1);
    send_message(0, 1'b1);

    // Random part: short messages until the item budget is spent.
    while (words_sent < 140) begin
      send_message($urandom_range(0, 12), 1'b1);
      if ($urandom_range(0, 5) == 0) drain_digests();
    end
    drain_digests();
    tail = 0;
    while (tail < 200) begin
      @(posedge clk);
      tail++;
    end

    $display("Sent %0d words in %0d messages; checked %0d digest words.",
             words_sent, messages_sent, i_tally.digests_seen);
    $display("Covered empty, padding-boundary and multi-block messages under stalls.");
    if (i_tally.fails == 0 && i_tally.pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
